[design/irpwd_pkg.sv]
// Package: shared types, constants and window compare for the IR pulse width decoder.
`default_nettype none

package irpwd_pkg;

    localparam int unsigned WIDTH_W = 16;
    localparam int unsigned NOM_W   = 12;
    localparam int unsigned TOL_W   = 8;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned INDEX_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_FULL = 6'd32;
    localparam logic [COUNT_W-1:0] COUNT_SAT  = 6'd33;

    localparam logic [TOL_W-1:0] RST_TOLERANCE = 8'd5;
    localparam logic [NOM_W-1:0] RST_START     = 12'd45;
    localparam logic [NOM_W-1:0] RST_END       = 12'd395;
    localparam logic [NOM_W-1:0] RST_REPEAT    = 12'd959;
    localparam logic [NOM_W-1:0] RST_ZERO      = 12'd6;
    localparam logic [NOM_W-1:0] RST_ONE       = 12'd17;
    localparam logic [NOM_W-1:0] RST_COMMA     = 12'd23;

    typedef enum logic [INDEX_W-1:0] {
        REG_TOL    = 3'd0,
        REG_START  = 3'd1,
        REG_END    = 3'd2,
        REG_REPEAT = 3'd3,
        REG_ZERO   = 3'd4,
        REG_ONE    = 3'd5,
        REG_COMMA  = 3'd6
    } reg_index_t;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_START,
        CLS_ONE,
        CLS_ZERO,
        CLS_END,
        CLS_REPEAT,
        CLS_COMMA
    } pulse_class_t;

    typedef struct packed {
        logic [TOL_W-1:0] tolerance;
        logic [NOM_W-1:0] start_width;
        logic [NOM_W-1:0] end_width;
        logic [NOM_W-1:0] repeat_width;
        logic [NOM_W-1:0] zero_width;
        logic [NOM_W-1:0] one_width;
        logic [NOM_W-1:0] comma_width;
    } cfg_t;

    // nominal - tol < w < nominal + tol, evaluated without wrap
    function automatic logic in_window(
        input logic [WIDTH_W-1:0] w,
        input logic [NOM_W-1:0]   nominal,
        input logic [TOL_W-1:0]   tol
    );
        logic [WIDTH_W:0] w_plus_tol;
        logic [WIDTH_W:0] nom_plus_tol;
        w_plus_tol   = {1'b0, w} + {{(WIDTH_W+1-TOL_W){1'b0}}, tol};
        nom_plus_tol = {{(WIDTH_W+1-NOM_W){1'b0}}, nominal}
                     + {{(WIDTH_W+1-TOL_W){1'b0}}, tol};
        in_window = (w_plus_tol > {{(WIDTH_W+1-NOM_W){1'b0}}, nominal})
                 && ({1'b0, w} < nom_plus_tol);
    endfunction

endpackage

`default_nettype wire

[design/irpwd_classify.sv]
// Pulse classifier: six prioritized acceptance windows.
`default_nettype none

module irpwd_classify (
    input  wire logic [irpwd_pkg::WIDTH_W-1:0] pulse_width,
    input  wire irpwd_pkg::cfg_t               cfg,
    output irpwd_pkg::pulse_class_t            pulse_class
);

    logic hit_start;
    logic hit_one;
    logic hit_zero;
    logic hit_end;
    logic hit_repeat;
    logic hit_comma;

    assign hit_start  = irpwd_pkg::in_window(pulse_width, cfg.start_width,  cfg.tolerance);
    assign hit_one    = irpwd_pkg::in_window(pulse_width, cfg.one_width,    cfg.tolerance);
    assign hit_zero   = irpwd_pkg::in_window(pulse_width, cfg.zero_width,   cfg.tolerance);
    assign hit_end    = irpwd_pkg::in_window(pulse_width, cfg.end_width,    cfg.tolerance);
    assign hit_repeat = irpwd_pkg::in_window(pulse_width, cfg.repeat_width, cfg.tolerance);
    assign hit_comma  = irpwd_pkg::in_window(pulse_width, cfg.comma_width,  cfg.tolerance);

    always_comb
    begin
        if (hit_start)
        begin
            pulse_class = irpwd_pkg::CLS_START;
        end
        else if (hit_one)
        begin
            pulse_class = irpwd_pkg::CLS_ONE;
        end
        else if (hit_zero)
        begin
            pulse_class = irpwd_pkg::CLS_ZERO;
        end
        else if (hit_end)
        begin
            pulse_class = irpwd_pkg::CLS_END;
        end
        else if (hit_repeat)
        begin
            pulse_class = irpwd_pkg::CLS_REPEAT;
        end
        else if (hit_comma)
        begin
            pulse_class = irpwd_pkg::CLS_COMMA;
        end
        else
        begin
            pulse_class = irpwd_pkg::CLS_NONE;
        end
    end

endmodule

`default_nettype wire

[design/ir_remote_pulse_width_decoder.sv]
// Top level: IR remote pulse width decoder (config regs, frame state, output register).
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, pulse_width           | sink
//   out     | out_valid, out_ready, command_code,       | source
//           | repeat_seen                               |
//   cfg     | cfg_write, cfg_index, cfg_data            | sink, no handshake
//
// A transaction is registered on input (pv_reg, pw_reg), then classified and applied
// to the frame state; a comma pulse loads the output register when it is applied.
// One transaction per cycle is accepted while the input does not stall.
// Input stalls only while a result waits in the output register and the
// registered pulse is a comma. Reset clears config to defaults and frame state.
`default_nettype none

module ir_remote_pulse_width_decoder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [irpwd_pkg::WIDTH_W-1:0]       pulse_width,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [irpwd_pkg::WORD_W-1:0]             command_code,
    output logic                                     repeat_seen,
    input  wire logic                                cfg_write,
    input  wire logic [irpwd_pkg::INDEX_W-1:0]       cfg_index,
    input  wire logic [irpwd_pkg::NOM_W-1:0]         cfg_data
);

    irpwd_pkg::cfg_t                    cfg_reg;
    logic                               pv_reg;
    logic [irpwd_pkg::WIDTH_W-1:0]      pw_reg;
    logic [irpwd_pkg::WORD_W-1:0]       shift_reg;
    logic [irpwd_pkg::WORD_W-1:0]       shift_next;
    logic [irpwd_pkg::COUNT_W-1:0]      count_reg;
    logic [irpwd_pkg::COUNT_W-1:0]      count_next;
    logic                               started_reg;
    logic                               started_next;
    logic                               rpt_reg;
    logic                               rpt_next;
    logic [irpwd_pkg::WORD_W-1:0]       latched_reg;
    logic [irpwd_pkg::WORD_W-1:0]       latched_next;
    logic                               ov_reg;
    logic [irpwd_pkg::WORD_W-1:0]       oc_reg;
    logic                               orpt_reg;
    irpwd_pkg::pulse_class_t            pulse_class;
    logic                               out_free;
    logic                               fire;
    logic                               emit;
    logic [4:0]                         bit_pos;

    irpwd_classify u_classify (
        .pulse_width (pw_reg),
        .cfg         (cfg_reg),
        .pulse_class (pulse_class)
    );

    assign out_free = !ov_reg || out_ready;
    assign fire     = pv_reg && ((pulse_class != irpwd_pkg::CLS_COMMA) || out_free);
    assign emit     = fire && (pulse_class == irpwd_pkg::CLS_COMMA);
    assign in_ready = !pv_reg || fire;
    assign bit_pos  = 5'd31 - count_reg[4:0];

    assign out_valid    = ov_reg;
    assign command_code = oc_reg;
    assign repeat_seen  = orpt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tolerance    <= irpwd_pkg::RST_TOLERANCE;
            cfg_reg.start_width  <= irpwd_pkg::RST_START;
            cfg_reg.end_width    <= irpwd_pkg::RST_END;
            cfg_reg.repeat_width <= irpwd_pkg::RST_REPEAT;
            cfg_reg.zero_width   <= irpwd_pkg::RST_ZERO;
            cfg_reg.one_width    <= irpwd_pkg::RST_ONE;
            cfg_reg.comma_width  <= irpwd_pkg::RST_COMMA;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                irpwd_pkg::REG_TOL:    cfg_reg.tolerance    <= cfg_data[irpwd_pkg::TOL_W-1:0];
                irpwd_pkg::REG_START:  cfg_reg.start_width  <= cfg_data;
                irpwd_pkg::REG_END:    cfg_reg.end_width    <= cfg_data;
                irpwd_pkg::REG_REPEAT: cfg_reg.repeat_width <= cfg_data;
                irpwd_pkg::REG_ZERO:   cfg_reg.zero_width   <= cfg_data;
                irpwd_pkg::REG_ONE:    cfg_reg.one_width    <= cfg_data;
                irpwd_pkg::REG_COMMA:  cfg_reg.comma_width  <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            pv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pw_reg <= pulse_width;
        end
    end

    always_comb
    begin
        shift_next   = shift_reg;
        count_next   = count_reg;
        started_next = started_reg;
        rpt_next     = rpt_reg;
        latched_next = latched_reg;
        case (pulse_class)
            irpwd_pkg::CLS_START:
            begin
                count_next   = '0;
                started_next = 1'b1;
            end
            irpwd_pkg::CLS_ONE, irpwd_pkg::CLS_ZERO:
            begin
                if (started_reg && (count_reg < irpwd_pkg::COUNT_FULL))
                begin
                    shift_next[bit_pos] = (pulse_class == irpwd_pkg::CLS_ONE);
                end
                if (count_reg < irpwd_pkg::COUNT_SAT)
                begin
                    count_next = count_reg + 6'd1;
                end
            end
            irpwd_pkg::CLS_END:
            begin
                latched_next = (started_reg && (count_reg == irpwd_pkg::COUNT_FULL))
                             ? shift_reg : '0;
                rpt_next     = 1'b0;
                started_next = 1'b0;
                count_next   = '0;
            end
            irpwd_pkg::CLS_REPEAT:
            begin
                rpt_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg   <= '0;
            count_reg   <= '0;
            started_reg <= 1'b0;
            rpt_reg     <= 1'b0;
            latched_reg <= '0;
        end
        else if (fire)
        begin
            shift_reg   <= shift_next;
            count_reg   <= count_next;
            started_reg <= started_next;
            rpt_reg     <= rpt_next;
            latched_reg <= latched_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (emit)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            oc_reg   <= latched_reg;
            orpt_reg <= rpt_reg;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= irpwd_pkg::COUNT_SAT)
        else $error("bit count beyond saturation");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (pv_reg && ov_reg && !out_ready))
        else $error("input stalled without a blocked result");

    a_start_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pulse_class == irpwd_pkg::CLS_START) |=> (started_reg && count_reg == '0))
        else $error("start pulse did not open a frame");

    a_end_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pulse_class == irpwd_pkg::CLS_END) |=>
            (!started_reg && !rpt_reg && count_reg == '0))
        else $error("end pulse did not close the frame");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (ov_reg && oc_reg == $past(latched_reg) && orpt_reg == $past(rpt_reg)))
        else $error("comma transaction did not load the result");

endmodule

`default_nettype wire

[verif/irpwd_frame_checker.sv]
// Scoreboard for the IR pulse width decoder: tracks frame state from accepted pulses and checks reports.
module irpwd_frame_checker
    import irpwd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [WIDTH_W-1:0] pulse_width,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [WORD_W-1:0]  command_code,
    input  wire logic               repeat_seen,
    input  wire logic               cfg_write,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [NOM_W-1:0]   cfg_data,
    output int                      fail_count,
    output int                      pending,
    output int                      reports_checked,
    output int                      frames_good
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WORD_W-1:0] code;
        logic              rep;
    } frame_report_t;

    cfg_t                cfg;
    logic [WORD_W-1:0]   shift_word;
    logic [COUNT_W-1:0]  bit_count;
    logic                frame_started;
    logic                repeat_mark;
    logic [WORD_W-1:0]   latched_command;
    frame_report_t       report_q[$];

    // strict bounds, signed so a negative lower edge admits zero
    function automatic logic fits(input logic [WIDTH_W-1:0] w, input logic [NOM_W-1:0] nom);
        int lo;
        int hi;
        lo = int'(nom) - int'(cfg.tolerance);
        hi = int'(nom) + int'(cfg.tolerance);
        return (int'(w) > lo) && (int'(w) < hi);
    endfunction

    function automatic pulse_class_t classify(input logic [WIDTH_W-1:0] w);
        if (fits(w, cfg.start_width))  return CLS_START;
        if (fits(w, cfg.one_width))    return CLS_ONE;
        if (fits(w, cfg.zero_width))   return CLS_ZERO;
        if (fits(w, cfg.end_width))    return CLS_END;
        if (fits(w, cfg.repeat_width)) return CLS_REPEAT;
        if (fits(w, cfg.comma_width))  return CLS_COMMA;
        return CLS_NONE;
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ERROR %s", $realtime, msg);
    endtask

    task automatic apply_pulse(input logic [WIDTH_W-1:0] w);
        pulse_class_t cls;
        cls = classify(w);
        case (cls)
            CLS_START:
            begin
                bit_count     = '0;
                frame_started = 1'b1;
            end
            CLS_ONE, CLS_ZERO:
            begin
                if (frame_started && bit_count < COUNT_FULL)
                    shift_word[WORD_W-1-int'(bit_count)] = (cls == CLS_ONE);
                if (bit_count < COUNT_SAT)
                    bit_count = bit_count + 1'b1;
            end
            CLS_END:
            begin
                if (frame_started && bit_count == COUNT_FULL)
                begin
                    latched_command = shift_word;
                    frames_good++;
                end
                else
                    latched_command = '0;
                repeat_mark   = 1'b0;
                frame_started = 1'b0;
                bit_count     = '0;
            end
            CLS_REPEAT:
                repeat_mark = 1'b1;
            CLS_COMMA:
                report_q.push_back('{code: latched_command, rep: repeat_mark});
            default:
                ;
        endcase
    endtask

    task automatic check_report();
        frame_report_t exp_r;
        if (report_q.size() == 0)
        begin
            log_failure($sformatf("unexpected report code=%h repeat=%0b",
                                  command_code, repeat_seen));
            return;
        end
        exp_r = report_q.pop_front();
        reports_checked++;
        if (command_code !== exp_r.code)
            log_failure($sformatf("report %0d command_code expected %h got %h",
                                  reports_checked, exp_r.code, command_code));
        if (repeat_seen !== exp_r.rep)
            log_failure($sformatf("report %0d repeat_seen expected %0b got %0b",
                                  reports_checked, exp_r.rep, repeat_seen));
    endtask

    initial
    begin
        fail_count      = 0;
        reports_checked = 0;
        frames_good     = 0;
        pending         = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.tolerance    = RST_TOLERANCE;
            cfg.start_width  = RST_START;
            cfg.end_width    = RST_END;
            cfg.repeat_width = RST_REPEAT;
            cfg.zero_width   = RST_ZERO;
            cfg.one_width    = RST_ONE;
            cfg.comma_width  = RST_COMMA;
            shift_word       = '0;
            bit_count        = '0;
            frame_started    = 1'b0;
            repeat_mark      = 1'b0;
            latched_command  = '0;
            report_q.delete();
            pending          = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TOL:    cfg.tolerance    = cfg_data[TOL_W-1:0];
                    REG_START:  cfg.start_width  = cfg_data;
                    REG_END:    cfg.end_width    = cfg_data;
                    REG_REPEAT: cfg.repeat_width = cfg_data;
                    REG_ZERO:   cfg.zero_width   = cfg_data;
                    REG_ONE:    cfg.one_width    = cfg_data;
                    REG_COMMA:  cfg.comma_width  = cfg_data;
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
                apply_pulse(pulse_width);
            if (out_valid && out_ready)
                check_report();
            pending = report_q.size();
        end
    end

endmodule

[verif/tb.sv]
// Testbench top: stimulus, reset, flow control and verdict for the IR pulse width decoder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import irpwd_pkg::*;

    localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 3000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [WIDTH_W-1:0] pulse_width;
    logic               out_valid;
    logic               out_ready;
    logic [WORD_W-1:0]  command_code;
    logic               repeat_seen;
    logic               cfg_write;
    logic [INDEX_W-1:0] cfg_index;
    logic [NOM_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int reports_checked;
    int frames_good;

    int   pulses_sent     = 0;
    int   settings_used   = 1;
    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    int   hold_off_cycles = 0;
    cfg_t cur;

    ir_remote_pulse_width_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pulse_width  (pulse_width),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command_code (command_code),
        .repeat_seen  (repeat_seen),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    irpwd_frame_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pulse_width     (pulse_width),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .command_code    (command_code),
        .repeat_seen     (repeat_seen),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .reports_checked (reports_checked),
        .frames_good     (frames_good)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when requested
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [WIDTH_W-1:0] near(input logic [NOM_W-1:0] nom);
        int lo;
        int hi;
        lo = int'(nom) - int'(cur.tolerance) + 1;
        hi = int'(nom) + int'(cur.tolerance) - 1;
        if (lo < 0)
            lo = 0;
        if (hi < lo)
            return WIDTH_W'(nom);
        return WIDTH_W'($urandom_range(hi, lo));
    endfunction

    function automatic cfg_t spread_settings();
        cfg_t s;
        int   gap;
        s.tolerance    = TOL_W'($urandom_range(1, 30));
        gap            = 2 * int'(s.tolerance);
        s.zero_width   = NOM_W'($urandom_range(0, 40));
        s.one_width    = NOM_W'(int'(s.zero_width) + gap + $urandom_range(0, 60));
        s.comma_width  = NOM_W'(int'(s.one_width) + gap + $urandom_range(0, 60));
        s.start_width  = NOM_W'(int'(s.comma_width) + gap + $urandom_range(0, 60));
        s.end_width    = NOM_W'(int'(s.start_width) + gap + $urandom_range(0, 60));
        s.repeat_width = NOM_W'(int'(s.end_width) + gap + $urandom_range(0, 60));
        return s;
    endfunction

    task automatic send_pulse(input logic [WIDTH_W-1:0] w);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        pulse_width <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pulses_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_settings(input cfg_t s);
        logic [NOM_W-1:0] vals [8];
        vals[REG_TOL]    = {4'($urandom), s.tolerance};
        vals[REG_START]  = s.start_width;
        vals[REG_END]    = s.end_width;
        vals[REG_REPEAT] = s.repeat_width;
        vals[REG_ZERO]   = s.zero_width;
        vals[REG_ONE]    = s.one_width;
        vals[REG_COMMA]  = s.comma_width;
        vals[REG_UNUSED] = NOM_W'($urandom);
        drain();
        cfg_write <= 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            cfg_index <= INDEX_W'(i);
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        cur = s;
        settings_used++;
    endtask

    task automatic send_frame(input int nbits);
        if ($urandom_range(0, 9) == 0)
            send_pulse(near(cur.repeat_width));
        send_pulse(near(cur.start_width));
        for (int i = 0; i < nbits; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                send_pulse(WIDTH_W'($urandom));
            send_pulse($urandom_range(0, 1) ? near(cur.one_width) : near(cur.zero_width));
        end
        if ($urandom_range(0, 9) != 0)
            send_pulse(near(cur.end_width));
        repeat ($urandom_range(0, 2)) send_pulse(near(cur.repeat_width));
        repeat ($urandom_range(1, 2)) send_pulse(near(cur.comma_width));
    endtask

    task automatic run_random(input int until_count);
        int pick;
        while (pulses_sent < until_count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                send_frame(($urandom_range(0, 3) != 0) ? 32 : $urandom_range(0, 35));
            else if (pick < 90)
                repeat ($urandom_range(1, 5)) send_pulse(WIDTH_W'($urandom));
            else
                send_pulse(WIDTH_W'($urandom_range(0, 4500)));
        end
    endtask

    task automatic run_noise(input int count);
        repeat (count)
            send_pulse(($urandom_range(0, 1) != 0) ? WIDTH_W'($urandom)
                                                   : WIDTH_W'($urandom_range(0, 300)));
    endtask

    initial
    begin : stimulus
        cfg_t s;
        logic [WIDTH_W-1:0] directed [] = '{
            23, 0, 65535, 17, 6, 40, 50, 41, 17, 6, 395, 959, 23,
            49, 12, 22, 21, 395, 23, 954, 964, 390
        };

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pulse_width = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cur.tolerance    = RST_TOLERANCE;
        cur.start_width  = RST_START;
        cur.end_width    = RST_END;
        cur.repeat_width = RST_REPEAT;
        cur.zero_width   = RST_ZERO;
        cur.one_width    = RST_ONE;
        cur.comma_width  = RST_COMMA;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset windows: boundaries, bits before start, overlap of one and comma
        foreach (directed[i])
            send_pulse(directed[i]);

        // reset settings, no idling; exact frame, overlong frame, receiver hold-off
        send_frame(32);
        send_frame(34);
        hold_off_cycles = 80;
        repeat (12) send_pulse(near(cur.comma_width));
        run_random(260);

        sender_idle_pct = 71;
        apply_settings(spread_settings());
        run_random(600);

        sender_idle_pct = 0;
        recv_stall_pct  = 71;
        apply_settings(spread_settings());
        run_random(800);
        hold_off_cycles = 120;
        repeat (16) send_pulse(near(cur.comma_width));
        run_random(950);

        sender_idle_pct = 9;
        recv_stall_pct  = 9;
        apply_settings(spread_settings());
        run_random(1120);
        drain();
        run_random(1300);

        // widest tolerance, zero window reaching below zero, top nominal
        sender_idle_pct = 0;
        recv_stall_pct  = 30;
        s.tolerance    = 8'd255;
        s.zero_width   = 12'd0;
        s.one_width    = 12'd600;
        s.comma_width  = 12'd1200;
        s.start_width  = 12'd1800;
        s.end_width    = 12'd2400;
        s.repeat_width = 12'd4095;
        apply_settings(s);
        run_random(1650);

        // every window on top of the others: start wins
        s.start_width  = 12'd0;
        s.end_width    = 12'd0;
        s.repeat_width = 12'd0;
        s.zero_width   = 12'd0;
        s.one_width    = 12'd0;
        s.comma_width  = 12'd0;
        apply_settings(s);
        run_noise(40);

        // zero tolerance: no window admits anything
        s = spread_settings();
        s.tolerance = 8'd0;
        apply_settings(s);
        run_noise(40);
        send_pulse(WIDTH_W'(s.comma_width));
        send_pulse(WIDTH_W'(s.start_width));

        drain();
        repeat (10) @(negedge clk);
        $display("Sent %0d pulses under %0d window settings with idle and stall mixes.",
                 pulses_sent, settings_used);
        $display("Checked %0d reports; %0d complete 32-bit frames latched.",
                 reports_checked, frames_good);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
